// ===== sv/zxkbd_pkg.sv =====
// Types and constants shared by the keyboard matrix port modules.
package zxkbd_pkg;

  localparam int unsigned NUM_ROWS = 8;
  localparam int unsigned ROW_KEYS = 5;
  localparam int unsigned KEY_BITS = NUM_ROWS * ROW_KEYS;
  localparam int unsigned PERIOD_W = 20;
  localparam int unsigned ACC_W    = 32;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [7:0] CMD_PLAY    = 8'h10;
  localparam logic [7:0] CMD_BACK    = 8'h20;
  localparam logic [7:0] CMD_FORWARD = 8'h40;
  localparam logic [7:0] CMD_STOP    = 8'h80;
  localparam logic [4:0] ROW_IDLE    = 5'h1F;
  localparam logic [7:0] FIXED_ONES  = 8'hA0;
  localparam logic [7:0] EAR_BIT     = 8'h40;
  localparam logic [15:0] EAR_UNDRIVEN = 16'hFFFF;
  localparam logic [PERIOD_W-1:0] DEFAULT_PERIOD = 20'd1000;

  typedef struct packed {
    logic                operation;
    logic [15:0]         tick_count;
    logic [KEY_BITS-1:0] pressed_keys;
    logic                f10_held;
    logic                up_held;
    logic                down_held;
    logic                left_held;
    logic                right_held;
    logic [15:0]         port_address;
    logic                ear_linked;
    logic [15:0]         ear_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] port_data;
    logic [7:0] tape_command;
    logic       command_changed;
    logic       scan_enabled;
  } out_item_t;

endpackage

// ===== sv/zxkbd_if.sv =====
// Valid/ready channel interfaces for input items and result items.
interface zxkbd_item_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [15:0] tick_count;
  logic [39:0] pressed_keys;
  logic        f10_held;
  logic        up_held;
  logic        down_held;
  logic        left_held;
  logic        right_held;
  logic [15:0] port_address;
  logic        ear_linked;
  logic [15:0] ear_value;

  modport source (
    output valid, operation, tick_count, pressed_keys, f10_held, up_held, down_held,
           left_held, right_held, port_address, ear_linked, ear_value,
    input  ready
  );
  modport sink (
    input  valid, operation, tick_count, pressed_keys, f10_held, up_held, down_held,
           left_held, right_held, port_address, ear_linked, ear_value,
    output ready
  );
endinterface

interface zxkbd_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] port_data;
  logic [7:0] tape_command;
  logic       command_changed;
  logic       scan_enabled;

  modport source (
    output valid, port_data, tape_command, command_changed, scan_enabled,
    input  ready
  );
  modport sink (
    input  valid, port_data, tape_command, command_changed, scan_enabled,
    output ready
  );
endinterface

// ===== sv/zxkbd_in_stage.sv =====
// Input register stage: captures one beat and holds it until it is executed.
module zxkbd_in_stage (
  input  logic              clk,
  input  logic              rst,
  zxkbd_item_if.sink        item,
  input  logic              take,
  output logic              held_valid,
  output zxkbd_pkg::in_item_t held
);
  import zxkbd_pkg::*;

  logic load;

  assign item.ready = !held_valid || take;
  assign load       = item.valid && item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (load) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held.operation    <= item.operation;
      held.tick_count   <= item.tick_count;
      held.pressed_keys <= item.pressed_keys;
      held.f10_held     <= item.f10_held;
      held.up_held      <= item.up_held;
      held.down_held    <= item.down_held;
      held.left_held    <= item.left_held;
      held.right_held   <= item.right_held;
      held.port_address <= item.port_address;
      held.ear_linked   <= item.ear_linked;
      held.ear_value    <= item.ear_value;
    end
  end
endmodule

// ===== sv/zxkbd_exec.sv =====
// Execution stage: keyboard state, sample timer, tape latch and port read logic.
module zxkbd_exec (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [zxkbd_pkg::PERIOD_W-1:0] cfg_wdata,
  input  logic                       fire,
  input  zxkbd_pkg::in_item_t        item,
  output zxkbd_pkg::out_item_t       result
);
  import zxkbd_pkg::*;

  logic [PERIOD_W-1:0] sample_period;
  logic                scan_on;
  logic                toggle_key_was_down;
  logic [ACC_W-1:0]    tick_accumulator;
  logic [7:0]          tape_latch;
  logic [KEY_BITS-1:0] row_bits;

  logic [PERIOD_W-1:0] period;
  logic [ACC_W:0]      sum;
  logic [ACC_W-1:0]    acc_sat;
  logic                sample_hit;
  logic                is_tick;
  logic                take_sample;
  logic                scan_next;
  logic [7:0]          cmd;
  logic                latch_change;
  logic [4:0]          keys;
  logic                ear;

  assign is_tick = (item.operation == OP_TICK);
  assign period  = (sample_period == '0) ? DEFAULT_PERIOD : sample_period;
  assign sum     = {1'b0, tick_accumulator} + {{(ACC_W + 1 - 16){1'b0}}, item.tick_count};
  assign acc_sat = sum[ACC_W] ? {ACC_W{1'b1}} : sum[ACC_W-1:0];
  assign sample_hit  = acc_sat >= {{(ACC_W - PERIOD_W){1'b0}}, period};
  assign take_sample = is_tick && sample_hit;
  assign scan_next   = scan_on ^ (item.f10_held && !toggle_key_was_down);

  always_comb begin
    cmd = tape_latch;
    if (item.up_held) begin
      cmd = CMD_PLAY;
    end else if (item.down_held) begin
      cmd = CMD_STOP;
    end else if (item.left_held) begin
      cmd = CMD_BACK;
    end else if (item.right_held) begin
      cmd = CMD_FORWARD;
    end
  end

  assign latch_change = take_sample && scan_next && (cmd != tape_latch);

  always_comb begin
    keys = ROW_IDLE;
    if (scan_on) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        if (!item.port_address[8 + r]) begin
          keys = keys & row_bits[r*ROW_KEYS +: ROW_KEYS];
        end
      end
    end
  end

  assign ear = !item.ear_linked || (item.ear_value == EAR_UNDRIVEN) || item.ear_value[0];

  always_comb begin
    result.command_changed = latch_change;
    result.tape_command    = latch_change ? cmd : tape_latch;
    result.scan_enabled    = take_sample ? scan_next : scan_on;
    if (is_tick) begin
      result.port_data = 8'h00;
    end else begin
      result.port_data = {3'b000, keys} | FIXED_ONES | (ear ? EAR_BIT : 8'h00);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_period       <= DEFAULT_PERIOD;
      scan_on             <= 1'b0;
      toggle_key_was_down <= 1'b0;
      tick_accumulator    <= '0;
      tape_latch          <= 8'h00;
      row_bits            <= {KEY_BITS{1'b1}};
    end else begin
      if (cfg_we) begin
        sample_period <= cfg_wdata;
      end
      if (fire && is_tick) begin
        tick_accumulator <= sample_hit ? acc_sat - {{(ACC_W - PERIOD_W){1'b0}}, period}
                                       : acc_sat;
        if (sample_hit) begin
          row_bits            <= ~item.pressed_keys;
          scan_on             <= scan_next;
          toggle_key_was_down <= item.f10_held;
          if (latch_change) begin
            tape_latch <= cmd;
          end
        end
      end
    end
  end
endmodule

// ===== sv/zxkbd_out_stage.sv =====
// Result register stage: holds one result beat until the sink takes it.
module zxkbd_out_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  zxkbd_pkg::out_item_t data,
  output logic                 space,
  zxkbd_result_if.source       result
);
  import zxkbd_pkg::*;

  out_item_t held;

  assign space = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= data;
    end
  end

  assign result.port_data       = held.port_data;
  assign result.tape_command    = held.tape_command;
  assign result.command_changed = held.command_changed;
  assign result.scan_enabled    = held.scan_enabled;
endmodule

// ===== sv/zx_keyboard_matrix_port_core.sv =====
// Top level of the keyboard matrix port.
// Each input beat is either a clock tick carrying a key snapshot or a port
// read, and gives exactly one result beat. A beat is held in the input
// register and is executed against the keyboard state as it moves into
// the result register, so a beat can be taken in every cycle; the only
// limit on rate is the sink taking results. A full result register stalls
// the input side. The sample period register may be written only while no
// beat is in flight; a value of zero acts as a period of 1000.
module zx_keyboard_matrix_port_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [19:0] cfg_wdata,
  zxkbd_item_if.sink      item,
  zxkbd_result_if.source  result
);
  import zxkbd_pkg::*;

  logic      held_valid;
  in_item_t  held;
  logic      space;
  logic      take;
  out_item_t exec_result;

  assign take = held_valid && space;

  zxkbd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .take       (take),
    .held_valid (held_valid),
    .held       (held)
  );

  zxkbd_exec u_exec (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fire      (take),
    .item      (held),
    .result    (exec_result)
  );

  zxkbd_out_stage u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (take),
    .data   (exec_result),
    .space  (space),
    .result (result)
  );
endmodule

// ===== sv/zxkbd_checker.sv =====
// Port-level checks for the keyboard matrix port, bound to the top level.
module zxkbd_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic [7:0] port_data,
  input logic [7:0] tape_command,
  input logic       command_changed,
  input logic       scan_enabled
);
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !res_valid)
    else $error("Result beat shown straight after reset.");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(port_data)
      && $stable(tape_command) && $stable(command_changed) && $stable(scan_enabled))
    else $error("Stalled result beat changed.");

  a_read_fixed_ones: assert property (@(posedge clk) disable iff (rst)
    res_valid && port_data != 8'h00 |-> port_data[7] && port_data[5]
      && (scan_enabled || port_data[4:0] == 5'h1F))
    else $error("Read data has wrong fixed bits or keys while scanning is off.");

  a_change_needs_scan: assert property (@(posedge clk) disable iff (rst)
    res_valid && command_changed |-> scan_enabled && port_data == 8'h00
      && (tape_command == 8'h10 || tape_command == 8'h20
          || tape_command == 8'h40 || tape_command == 8'h80))
    else $error("Tape command change reported outside a scanning tick.");
endmodule

bind zx_keyboard_matrix_port_core zxkbd_checker u_checker (
  .clk             (clk),
  .rst             (rst),
  .res_valid       (result.valid),
  .res_ready       (result.ready),
  .port_data       (result.port_data),
  .tape_command    (result.tape_command),
  .command_changed (result.command_changed),
  .scan_enabled    (result.scan_enabled)
);
